// File: rtl/sysres_pkg.sv
// Shared types and constants for the systematic resampler.
// Item structs, result codes, phase and controller state enums, command/status structs.
// No dependencies.
package sysres_pkg;

   // Fixed field widths
   localparam int SUM_W    = 44;
   localparam int IN_W_W   = 32;
   localparam int FRAC_W   = 16;
   localparam int IDX_W    = 12;
   localparam int STATUS_W = 3;

   // Operation codes
   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_FETCH = 1'b1
   } op_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      RS_INDEX  = 3'd0,
      RS_LOADED = 3'd1,
      RS_RESET  = 3'd2,
      RS_FAILED = 3'd3,
      RS_EMPTY  = 3'd4
   } status_type;

   // Set phase
   typedef enum logic [1:0] {
      PH_EMPTY   = 2'd0,
      PH_LOADING = 2'd1,
      PH_WALKING = 2'd2,
      PH_IDLE    = 2'd3
   } phase_type;

   // Controller states
   typedef enum logic [2:0] {
      CS_IDLE,
      CS_LOAD,
      CS_INIT,
      CS_FETCH,
      CS_MUL,
      CS_CMP
   } ctrl_state_type;

   // Input item
   typedef struct packed {
      logic              operation;
      logic [IN_W_W-1:0] weight;
      logic              last_weight;
      logic [FRAC_W-1:0] start_fraction;
   } req_type;

   // Result item
   typedef struct packed {
      status_type       status;
      logic [IDX_W-1:0] chosen_index;
      logic             last_index;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic       capture;
      logic       do_load;
      logic       init_rhs;
      logic       rd_en;
      logic       rd_next;
      logic       mul;
      logic       walk_inc;
      logic       phase_idle;
      logic       slot_adv;
      logic       rsp_load;
      status_type rsp_status;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last_weight;
      logic below_min;
      logic walking;
      logic in_range;
      logic next_in_range;
      logic le;
   } dp_stat_type;

endpackage

// File: rtl/sysres_dpath.sv
// Resampler datapath: item register, cumulative store, counters, products and compare.
// Driven by sysres_ctrl through ctrl_cmd_type; uses sysres_pkg.
module sysres_dpath
   import sysres_pkg::*;
#(
   parameter int MAX_PARTICLES = 4096,
   parameter int WEIGHT_BITS   = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  req_type            req_data,
   input  logic               csr_wr_en,
   input  logic [SUM_W-1:0]   csr_wr_data,
   input  ctrl_cmd_type       cmd,
   output dp_stat_type        stat,
   output rsp_type            rsp_data
);

   localparam int ADDR_W = $clog2(MAX_PARTICLES);
   localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
   localparam int LHS_W  = SUM_W + CNT_W;
   localparam int PROD_W = SUM_W + CNT_W + FRAC_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PARTICLES);

   // Registers
   req_type            req_ff, req_in;
   logic [SUM_W-1:0]   min_ff, min_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SUM_W-1:0]   total_ff, total_in;
   logic [CNT_W-1:0]   walk_ff, walk_in;
   logic [CNT_W-1:0]   slot_ff, slot_in;
   logic [FRAC_W-1:0]  start_ff, start_in;
   phase_type          phase_ff, phase_in;
   logic [PROD_W-1:0]  rhs_ff, rhs_in;
   logic [LHS_W-1:0]   lhs_ff, lhs_in;
   logic [SUM_W-1:0]   rd_data_ff;
   rsp_type            rsp_ff, rsp_in;

   // Cumulative store
   logic [SUM_W-1:0]   mem [MAX_PARTICLES];

   // Combinational terms
   logic               fresh;
   logic [CNT_W-1:0]   base_count;
   logic [SUM_W-1:0]   base_total;
   logic [SUM_W-1:0]   weight_ext;
   logic [SUM_W:0]     sum_wide;
   logic [SUM_W-1:0]   sum_sat;
   logic               has_room;
   logic [SUM_W-1:0]   load_total;
   logic [CNT_W-1:0]   load_count;
   logic [CNT_W-1:0]   walk_next;
   logic [CNT_W-1:0]   slot_next;
   logic [LHS_W-1:0]   prod_n;
   logic [SUM_W+FRAC_W-1:0] prod_u;
   logic               mem_we;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;

   // Load arithmetic: a load after a closed set (walking or idle) starts a new set
   assign fresh      = (phase_ff == PH_WALKING) || (phase_ff == PH_IDLE);
   assign base_count = fresh ? '0 : count_ff;
   assign base_total = fresh ? '0 : total_ff;
   assign weight_ext = SUM_W'(req_ff.weight[WEIGHT_BITS-1:0]);
   assign sum_wide   = {1'b0, base_total} + {1'b0, weight_ext};
   assign sum_sat    = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
   assign has_room   = base_count < MAX_CNT;
   assign load_total = has_room ? sum_sat : base_total;
   assign load_count = has_room ? base_count + CNT_W'(1) : base_count;

   // Walk arithmetic
   assign walk_next = walk_ff + CNT_W'(1);
   assign slot_next = slot_ff + CNT_W'(1);
   assign prod_n    = rd_data_ff * count_ff;
   assign prod_u    = total_ff * start_ff;

   // Store ports
   assign mem_we  = cmd.do_load && has_room;
   assign wr_addr = base_count[ADDR_W-1:0];
   assign rd_addr = cmd.rd_next ? walk_next[ADDR_W-1:0] : walk_ff[ADDR_W-1:0];

   // Status to controller
   always_comb begin
      stat.last_weight   = req_ff.last_weight;
      stat.below_min     = load_total <= min_ff;
      stat.walking       = (phase_ff == PH_WALKING);
      stat.in_range      = walk_ff < count_ff;
      stat.next_in_range = walk_next < count_ff;
      stat.le            = {lhs_ff, FRAC_W'(0)} <= rhs_ff;
   end

   // Next values
   always_comb begin
      req_in   = req_ff;
      min_in   = min_ff;
      count_in = count_ff;
      total_in = total_ff;
      walk_in  = walk_ff;
      slot_in  = slot_ff;
      start_in = start_ff;
      phase_in = phase_ff;
      rhs_in   = rhs_ff;
      lhs_in   = lhs_ff;
      rsp_in   = rsp_ff;

      if (cmd.capture) begin
         req_in = req_data;
      end
      if (csr_wr_en) begin
         min_in = csr_wr_data;
      end

      // Load one weight; the last one closes the set
      if (cmd.do_load) begin
         count_in = load_count;
         total_in = load_total;
         phase_in = PH_LOADING;
         if (req_ff.last_weight) begin
            start_in = req_ff.start_fraction;
            walk_in  = '0;
            slot_in  = '0;
            phase_in = stat.below_min ? PH_IDLE : PH_WALKING;
         end
      end

      // First target is total * u
      if (cmd.init_rhs) begin
         rhs_in = PROD_W'(prod_u);
      end
      if (cmd.mul) begin
         lhs_in = prod_n;
      end
      if (cmd.walk_inc) begin
         walk_in = walk_next;
      end
      if (cmd.phase_idle) begin
         phase_in = PH_IDLE;
      end

      // Index delivered: next slot, target grows by total << 16
      if (cmd.slot_adv) begin
         slot_in = slot_next;
         rhs_in  = rhs_ff + PROD_W'({total_ff, FRAC_W'(0)});
         if (slot_next >= count_ff) begin
            phase_in = PH_IDLE;
         end
      end

      if (cmd.rsp_load) begin
         rsp_in.status       = cmd.rsp_status;
         rsp_in.chosen_index = cmd.slot_adv ? IDX_W'(walk_ff) : '0;
         rsp_in.last_index   = cmd.slot_adv && (slot_next == count_ff);
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= SUM_W'(1);
         count_ff <= '0;
         total_ff <= '0;
         walk_ff  <= '0;
         slot_ff  <= '0;
         start_ff <= '0;
         phase_ff <= PH_EMPTY;
         rhs_ff   <= '0;
      end else begin
         min_ff   <= min_in;
         count_ff <= count_in;
         total_ff <= total_in;
         walk_ff  <= walk_in;
         slot_ff  <= slot_in;
         start_ff <= start_in;
         phase_ff <= phase_in;
         rhs_ff   <= rhs_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      lhs_ff <= lhs_in;
      rsp_ff <= rsp_in;
   end

   // Store write
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= sum_sat;
      end
   end

   // Store read, registered
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: rtl/sysres_ctrl.sv
// Resampler controller: sequences load, target setup and the walk loop; owns rsp valid.
// Talks to sysres_dpath through ctrl_cmd_type / dp_stat_type; uses sysres_pkg.
module sysres_ctrl
   import sysres_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_fetch,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // Output register can take a result this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               state_in = req_fetch ? CS_FETCH : CS_LOAD;
            end
         end
         CS_LOAD: begin
            if (out_free) begin
               state_in = stat.last_weight ? CS_INIT : CS_IDLE;
            end
         end
         CS_INIT: begin
            state_in = CS_IDLE;
         end
         CS_FETCH: begin
            if (stat.walking && stat.in_range) begin
               state_in = CS_MUL;
            end else if (out_free) begin
               state_in = CS_IDLE;
            end
         end
         CS_MUL: begin
            state_in = CS_CMP;
         end
         CS_CMP: begin
            if (stat.le && stat.next_in_range) begin
               state_in = CS_MUL;
            end else if (out_free) begin
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   // Commands
   always_comb begin
      cmd            = '0;
      cmd.rsp_status = RS_LOADED;
      unique case (state_ff)
         CS_IDLE: begin
            cmd.capture = req_valid;
         end
         CS_LOAD: begin
            if (out_free) begin
               cmd.do_load    = 1'b1;
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = (stat.last_weight && stat.below_min) ? RS_RESET : RS_LOADED;
            end
         end
         CS_INIT: begin
            cmd.init_rhs = 1'b1;
         end
         CS_FETCH: begin
            priority if (!stat.walking) begin
               cmd.rsp_load   = out_free;
               cmd.rsp_status = RS_EMPTY;
            end else if (!stat.in_range) begin
               cmd.rsp_load   = out_free;
               cmd.phase_idle = out_free;
               cmd.rsp_status = RS_FAILED;
            end else begin
               cmd.rd_en = 1'b1;
            end
         end
         CS_MUL: begin
            cmd.mul = 1'b1;
         end
         CS_CMP: begin
            priority if (stat.le && stat.next_in_range) begin
               // advance and read the next entry
               cmd.walk_inc = 1'b1;
               cmd.rd_en    = 1'b1;
               cmd.rd_next  = 1'b1;
            end else if (stat.le) begin
               // walked off the end
               cmd.walk_inc   = out_free;
               cmd.phase_idle = out_free;
               cmd.rsp_load   = out_free;
               cmd.rsp_status = RS_FAILED;
            end else begin
               cmd.slot_adv   = out_free;
               cmd.rsp_load   = out_free;
               cmd.rsp_status = RS_INDEX;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Result valid
   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != CS_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/systematic_resampler_top.sv
// Systematic resampler top level: controller plus datapath with cumulative store.
// Depends on sysres_pkg, sysres_ctrl and sysres_dpath.
//
//   channel | ports                          | moves
//   --------+--------------------------------+-----------------------------------
//   request | req_valid, req_stall, req_data | load weight / fetch index items
//   result  | rsp_valid, rsp_stall, rsp_data | one status item per request item
//   config  | csr_wr_en, csr_wr_data         | min_total_weight, no read-back
//
// A load captures the item and then loads it; the last weight of a set adds a step for total * u.
// A fetch walks the stored positions in order from the current one: each compared
// position costs a store read then one multiply and compare (store read -> mul -> cmp).
// Synchronous reset clears control state; the store is not cleared, the count bounds reads.
// A new item is taken while a result waits in the output register; the item then holds
// in its final step until rsp_stall drops.
module systematic_resampler_top
   import sysres_pkg::*;
#(
   parameter int MAX_PARTICLES = 4096,
   parameter int WEIGHT_BITS   = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [SUM_W-1:0] csr_wr_data
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;
   logic         req_fetch;

   assign req_fetch = (req_data.operation == OP_FETCH);

   sysres_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_fetch (req_fetch),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sysres_dpath #(
      .MAX_PARTICLES (MAX_PARTICLES),
      .WEIGHT_BITS   (WEIGHT_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_data    (rsp_data)
   );

   // One item in flight: an accepted item blocks the port next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while previous item still in work");

   // A stalled result stays valid and unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result changed while stalled");

   // Index fields are zero unless a chosen index is reported
   a_index_only_on_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == RS_LOADED || rsp_data.status == RS_RESET ||
                     rsp_data.status == RS_FAILED || rsp_data.status == RS_EMPTY))
      |-> (rsp_data.chosen_index == '0 && !rsp_data.last_index))
      else $error("index fields set on a non-index result");

endmodule
